// File: rtl/bba_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int MEM_ORDER    = 16;
    localparam int MIN_ORDER    = 5;
    localparam int HEADER_BYTES = 24;

    localparam int GRAN_W    = MEM_ORDER - MIN_ORDER;
    localparam int GRANULES  = 1 << GRAN_W;
    localparam int LINK_W    = GRAN_W + 1;
    localparam int NUM_LISTS = 16;
    localparam int LIST_W    = 4;
    localparam int ORD_W     = 5;
    localparam int BYTES_W   = 17;
    localparam int TOT_W     = BYTES_W + 1;
    localparam int OFF_W     = 16;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(GRANULES);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHECK,
        S_SPLIT_RD,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_FIN_RD,
        S_FIN_WR,
        S_F_CHECK,
        S_F_USE,
        S_M_RD,
        S_M_CHK,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               command;
        logic [BYTES_W-1:0] request_bytes;
        logic [OFF_W-1:0]   release_offset;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   granted_offset;
        logic [BYTES_W-1:0] used_total;
        logic [BYTES_W-1:0] free_total;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/bba_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba interfaces
// Valid/ready channels of the allocator: request, response, configuration.
// ---------------------------------------------------------------------------
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [bba_pkg::BYTES_W-1:0] request_bytes;
    logic [bba_pkg::OFF_W-1:0]   release_offset;

    modport source (output valid, command, request_bytes, release_offset, input ready);
    modport sink   (input valid, command, request_bytes, release_offset, output ready);
endinterface

interface bba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [bba_pkg::OFF_W-1:0]   granted_offset;
    logic [bba_pkg::BYTES_W-1:0] used_total;
    logic [bba_pkg::BYTES_W-1:0] free_total;

    modport source (output valid, status, granted_offset, used_total, free_total,
                    input ready);
    modport sink   (input valid, status, granted_offset, used_total, free_total,
                    output ready);
endinterface

interface bba_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bba_pkg::ORD_W-1:0] arena_order;

    modport source (output valid, arena_order, input ready);
    modport sink   (input valid, arena_order, output ready);
endinterface
`default_nettype wire

// File: rtl/buddy_block_allocator_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator over a power-of-two arena with per-granule tables in RAM.
// ---------------------------------------------------------------------------
//   channel  dir  payload                                          handshake
//   req      in   command, request_bytes, release_offset           valid/ready
//   rsp      out  status, granted_offset, used_total, free_total   valid/ready
//   cfg      in   arena_order                                      valid/ready
//
// allocate: check, a read and two writes per split level, a read and a write
// for the chosen block. free: check, in-use read, a read and a check per buddy
// probed, one list write and a second when the target list is not empty. all
// set by the single read port of the table RAMs. one item is in work at a time.
// after reset and after every cfg write a clearing pass runs over all 2048
// entries of all four tables; req is not ready during it.
// the response register lets the next item in while a result waits on rsp.
// ---------------------------------------------------------------------------
module buddy_block_allocator_unit (
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp,
    bba_cfg_if.sink    cfg
);

    logic [bba_pkg::ORD_W-1:0] arena_order_reg, arena_order_next;
    logic                      reinit_reg;
    logic                      out_valid_reg;
    bba_pkg::result_t          out_reg;
    bba_pkg::item_t            item;
    bba_pkg::result_t          res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      item_ready;

    // clamp the written order into the supported range
    always_comb
    begin
        arena_order_next = cfg.arena_order;
        if (cfg.arena_order < bba_pkg::ORD_W'(bba_pkg::MIN_ORDER))
        begin
            arena_order_next = bba_pkg::ORD_W'(bba_pkg::MIN_ORDER);
        end
        else if (cfg.arena_order > bba_pkg::ORD_W'(bba_pkg::MEM_ORDER))
        begin
            arena_order_next = bba_pkg::ORD_W'(bba_pkg::MEM_ORDER);
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_order_reg <= bba_pkg::ORD_W'(bba_pkg::MEM_ORDER);
            reinit_reg      <= 1'b0;
        end
        else
        begin
            reinit_reg <= cfg.valid;
            if (cfg.valid)
            begin
                arena_order_reg <= arena_order_next;
            end
        end
    end

    assign item.command        = req.command;
    assign item.request_bytes  = req.request_bytes;
    assign item.release_offset = req.release_offset;
    assign req.ready           = item_ready;

    bba_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .arena_order(arena_order_reg),
        .reinit     (reinit_reg)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.granted_offset = out_reg.granted_offset;
    assign rsp.used_total     = out_reg.used_total;
    assign rsp.free_total     = out_reg.free_total;

    a_totals_cover_arena: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.used_total + rsp.free_total) ==
                      (bba_pkg::BYTES_W'(1) << arena_order_reg))
        else $error("used and free totals do not add up to the arena");

    a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != 2'(bba_pkg::ST_OK)) |-> rsp.granted_offset == '0)
        else $error("failed item carries an offset");

    a_cfg_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> !req.ready)
        else $error("item taken while the arena is being rebuilt");

endmodule
`default_nettype wire

// File: rtl/bba_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/bba_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bba_engine
// Sequencer that walks the per-granule tables for split, merge and list ops.
// ---------------------------------------------------------------------------
module bba_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  bba_pkg::item_t            item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output bba_pkg::result_t          res,
    input  logic [bba_pkg::ORD_W-1:0] arena_order,
    input  logic                      reinit
);

    localparam int GW = bba_pkg::GRAN_W;
    localparam int LW = bba_pkg::LINK_W;
    localparam int OW = bba_pkg::ORD_W;
    localparam int BW = bba_pkg::BYTES_W;
    localparam int TW = bba_pkg::TOT_W;
    localparam int FW = bba_pkg::OFF_W;

    bba_pkg::state_t  state_reg, state_next;
    bba_pkg::item_t   item_reg, item_next;
    bba_pkg::status_t status_reg, status_next;
    logic [GW-1:0]    g_reg, g_next;
    logic [GW-1:0]    b_reg, b_next;
    logic [OW-1:0]    ord_reg, ord_next;
    logic [OW-1:0]    need_reg, need_next;
    logic [LW-1:0]    nxt_reg, nxt_next;
    logic [BW-1:0]    bytes_reg, bytes_next;
    logic [FW-1:0]    granted_reg, granted_next;
    logic [GW-1:0]    clr_reg, clr_next;
    logic [LW-1:0]    head_reg [bba_pkg::NUM_LISTS];
    logic [LW-1:0]    head_next [bba_pkg::NUM_LISTS];

    // table ports
    logic [GW-1:0] raddr;
    logic          ord_we, use_we, nxt_we, prv_we;
    logic [GW-1:0] ord_waddr, use_waddr, nxt_waddr, prv_waddr;
    logic [OW-1:0] ord_wdata, ord_rdata;
    logic          use_wdata, use_rdata;
    logic [LW-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

    logic [bba_pkg::LIST_W-1:0] hidx;
    logic [LW-1:0]              head_rd;
    logic [TW-1:0]              total;
    logic [TW-1:0]              arena_bytes;
    logic [OW-1:0]              need;
    logic [OW-1:0]              avail;
    logic                       found;
    logic [GW-1:0]              gh;
    logic [GW-1:0]              buddy;
    logic [FW-1:0]              start;

    bba_ram #(.WIDTH(OW), .DEPTH(bba_pkg::GRANULES)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(raddr), .rdata(ord_rdata));
    bba_ram #(.WIDTH(1), .DEPTH(bba_pkg::GRANULES)) u_in_use (
        .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
        .raddr(raddr), .rdata(use_rdata));
    bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::GRANULES)) u_next (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(raddr), .rdata(nxt_rdata));
    bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::GRANULES)) u_prev (
        .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(raddr), .rdata(prv_rdata));

    assign total       = TW'(item_reg.request_bytes) + TW'(bba_pkg::HEADER_BYTES);
    assign arena_bytes = TW'(1) << arena_order;
    assign start       = item_reg.release_offset - FW'(bba_pkg::HEADER_BYTES);
    assign gh          = g_reg + (GW'(1) << (ord_reg - OW'(bba_pkg::MIN_ORDER + 1)));
    assign buddy       = g_reg ^ (GW'(1) << (ord_reg - OW'(bba_pkg::MIN_ORDER)));

    always_comb
    begin
        if (state_reg == bba_pkg::S_FIN_RD || state_reg == bba_pkg::S_FIN_WR)
        begin
            hidx = bba_pkg::LIST_W'(need_reg - OW'(1));
        end
        else
        begin
            hidx = bba_pkg::LIST_W'(ord_reg - OW'(1));
        end
    end

    assign head_rd = head_reg[hidx];

    // smallest order that holds header plus request
    always_comb
    begin
        need = OW'(bba_pkg::MEM_ORDER);
        for (int k = bba_pkg::MEM_ORDER; k >= bba_pkg::MIN_ORDER; k--)
        begin
            if ((TW'(1) << k) >= total)
            begin
                need = OW'(k);
            end
        end
    end

    // lowest non-empty list at or above need
    always_comb
    begin
        found = 1'b0;
        avail = need;
        for (int k = bba_pkg::MIN_ORDER; k <= bba_pkg::MEM_ORDER; k++)
        begin
            if (!found && OW'(k) >= need && OW'(k) <= arena_order &&
                head_reg[(k - 1) % bba_pkg::NUM_LISTS] != bba_pkg::NIL)
            begin
                found = 1'b1;
                avail = OW'(k);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        g_next       = g_reg;
        b_next       = b_reg;
        ord_next     = ord_reg;
        need_next    = need_reg;
        nxt_next     = nxt_reg;
        bytes_next   = bytes_reg;
        granted_next = granted_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        raddr        = g_reg;
        ord_we       = 1'b0;
        ord_waddr    = g_reg;
        ord_wdata    = ord_reg;
        use_we       = 1'b0;
        use_waddr    = g_reg;
        use_wdata    = 1'b0;
        nxt_we       = 1'b0;
        nxt_waddr    = g_reg;
        nxt_wdata    = bba_pkg::NIL;
        prv_we       = 1'b0;
        prv_waddr    = g_reg;
        prv_wdata    = bba_pkg::NIL;
        item_ready   = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                ord_we    = 1'b1;
                ord_waddr = clr_reg;
                ord_wdata = (clr_reg == '0) ? arena_order : '0;
                use_we    = 1'b1;
                use_waddr = clr_reg;
                nxt_we    = 1'b1;
                nxt_waddr = clr_reg;
                prv_we    = 1'b1;
                prv_waddr = clr_reg;
                if (&clr_reg)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
                clr_next = clr_reg + GW'(1);
            end
            bba_pkg::S_IDLE:
            begin
                item_ready = !reinit;
                if (item_valid && !reinit)
                begin
                    item_next    = item;
                    status_next  = bba_pkg::ST_OK;
                    granted_next = '0;
                    state_next   = (item.command == bba_pkg::CMD_ALLOC) ?
                                   bba_pkg::S_A_CHECK : bba_pkg::S_F_CHECK;
                end
            end
            bba_pkg::S_A_CHECK:
            begin
                if (item_reg.request_bytes == '0 || total > arena_bytes)
                begin
                    status_next = bba_pkg::ST_BAD_SIZE;
                    state_next  = bba_pkg::S_DONE;
                end
                else if (!found)
                begin
                    status_next = bba_pkg::ST_NO_SPACE;
                    state_next  = bba_pkg::S_DONE;
                end
                else
                begin
                    ord_next   = avail;
                    need_next  = need;
                    state_next = (avail > need) ? bba_pkg::S_SPLIT_RD : bba_pkg::S_FIN_RD;
                end
            end
            bba_pkg::S_SPLIT_RD:
            begin
                raddr      = head_rd[GW-1:0];
                g_next     = head_rd[GW-1:0];
                state_next = bba_pkg::S_SPLIT_W1;
            end
            bba_pkg::S_SPLIT_W1:
            begin
                // unlink the head, low half goes back on the list below
                if (nxt_rdata != bba_pkg::NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[GW-1:0];
                end
                ord_we    = 1'b1;
                ord_wdata = ord_reg - OW'(1);
                nxt_we    = 1'b1;
                nxt_wdata = LW'(gh);
                head_next[hidx]                       = nxt_rdata;
                head_next[hidx - bba_pkg::LIST_W'(1)] = LW'(g_reg);
                state_next = bba_pkg::S_SPLIT_W2;
            end
            bba_pkg::S_SPLIT_W2:
            begin
                ord_we    = 1'b1;
                ord_waddr = gh;
                ord_wdata = ord_reg - OW'(1);
                nxt_we    = 1'b1;
                nxt_waddr = gh;
                prv_we    = 1'b1;
                prv_waddr = gh;
                prv_wdata = LW'(g_reg);
                ord_next  = ord_reg - OW'(1);
                state_next = (ord_reg - OW'(1) > need_reg) ?
                             bba_pkg::S_SPLIT_RD : bba_pkg::S_FIN_RD;
            end
            bba_pkg::S_FIN_RD:
            begin
                raddr      = head_rd[GW-1:0];
                g_next     = head_rd[GW-1:0];
                state_next = bba_pkg::S_FIN_WR;
            end
            bba_pkg::S_FIN_WR:
            begin
                head_next[hidx] = nxt_rdata;
                if (nxt_rdata != bba_pkg::NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[GW-1:0];
                end
                ord_we       = 1'b1;
                ord_wdata    = need_reg;
                use_we       = 1'b1;
                use_wdata    = 1'b1;
                bytes_next   = bytes_reg + (BW'(1) << need_reg);
                granted_next = FW'({g_reg, {bba_pkg::MIN_ORDER{1'b0}}}) +
                               FW'(bba_pkg::HEADER_BYTES);
                state_next   = bba_pkg::S_DONE;
            end
            bba_pkg::S_F_CHECK:
            begin
                if (item_reg.release_offset < FW'(bba_pkg::HEADER_BYTES) ||
                    start[bba_pkg::MIN_ORDER-1:0] != '0 || TW'(start) >= arena_bytes)
                begin
                    status_next = bba_pkg::ST_BAD_FREE;
                    state_next  = bba_pkg::S_DONE;
                end
                else
                begin
                    raddr      = start[FW-1:bba_pkg::MIN_ORDER];
                    g_next     = start[FW-1:bba_pkg::MIN_ORDER];
                    state_next = bba_pkg::S_F_USE;
                end
            end
            bba_pkg::S_F_USE:
            begin
                if (!use_rdata)
                begin
                    status_next = bba_pkg::ST_BAD_FREE;
                    state_next  = bba_pkg::S_DONE;
                end
                else
                begin
                    use_we     = 1'b1;
                    bytes_next = bytes_reg - (BW'(1) << ord_rdata);
                    ord_next   = ord_rdata;
                    state_next = (ord_rdata < arena_order) ? bba_pkg::S_M_RD : bba_pkg::S_PUSH1;
                end
            end
            bba_pkg::S_M_RD:
            begin
                raddr      = buddy;
                b_next     = buddy;
                state_next = bba_pkg::S_M_CHK;
            end
            bba_pkg::S_M_CHK:
            begin
                if (use_rdata || ord_rdata != ord_reg)
                begin
                    state_next = bba_pkg::S_PUSH1;
                end
                else
                begin
                    // take the buddy off its list and grow the block
                    if (prv_rdata >= bba_pkg::NIL)
                    begin
                        head_next[hidx] = nxt_rdata;
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rdata[GW-1:0];
                        nxt_wdata = nxt_rdata;
                    end
                    if (nxt_rdata != bba_pkg::NIL)
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rdata[GW-1:0];
                        prv_wdata = prv_rdata;
                    end
                    ord_we     = 1'b1;
                    ord_waddr  = (b_reg < g_reg) ? b_reg : g_reg;
                    ord_wdata  = ord_reg + OW'(1);
                    g_next     = (b_reg < g_reg) ? b_reg : g_reg;
                    ord_next   = ord_reg + OW'(1);
                    state_next = (ord_reg + OW'(1) < arena_order) ?
                                 bba_pkg::S_M_RD : bba_pkg::S_PUSH1;
                end
            end
            bba_pkg::S_PUSH1:
            begin
                ord_we          = 1'b1;
                nxt_we          = 1'b1;
                nxt_wdata       = head_rd;
                prv_we          = 1'b1;
                head_next[hidx] = LW'(g_reg);
                nxt_next        = head_rd;
                state_next      = (head_rd != bba_pkg::NIL) ? bba_pkg::S_PUSH2 : bba_pkg::S_DONE;
            end
            bba_pkg::S_PUSH2:
            begin
                prv_we     = 1'b1;
                prv_waddr  = nxt_reg[GW-1:0];
                prv_wdata  = LW'(g_reg);
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase

        // new arena: one free block of the full order, then sweep the tables
        if (reinit)
        begin
            state_next = bba_pkg::S_CLEAR;
            clr_next   = '0;
            bytes_next = '0;
            for (int i = 0; i < bba_pkg::NUM_LISTS; i++)
            begin
                head_next[i] = bba_pkg::NIL;
            end
            head_next[bba_pkg::LIST_W'(arena_order - OW'(1))] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
            clr_reg   <= '0;
            bytes_reg <= '0;
            for (int i = 0; i < bba_pkg::NUM_LISTS; i++)
            begin
                head_reg[i] <= bba_pkg::NIL;
            end
            head_reg[bba_pkg::LIST_W'(bba_pkg::MEM_ORDER - 1)] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            bytes_reg <= bytes_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        status_reg  <= status_next;
        g_reg       <= g_next;
        b_reg       <= b_next;
        ord_reg     <= ord_next;
        need_reg    <= need_next;
        nxt_reg     <= nxt_next;
        granted_reg <= granted_next;
    end

    assign res.status         = status_reg;
    assign res.granted_offset = granted_reg;
    assign res.used_total     = bytes_reg;
    assign res.free_total     = BW'(arena_bytes) - bytes_reg;

endmodule
`default_nettype wire
